### hdl/average_pool_stream_defines.svh
// assertion macros for the average pooling block
`ifndef AVERAGE_POOL_STREAM_DEFINES_SVH
`define AVERAGE_POOL_STREAM_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define AVGP_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");
// next-cycle implication
`define AVGP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define AVGP_ASSERT_IMPL(label, clk, rst, ante, cons)
`define AVGP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### hdl/avgp_pkg.sv
// shared types and constants of the average pooling block
package avgp_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_SIZE    = 1'd1;

  // register resets and limits
  localparam logic [4:0] KERNEL_RESET = 5'd2;
  localparam logic [8:0] MAP_RESET    = 9'd8;
  localparam logic [8:0] KSQ_RESET    = 9'd4;
  localparam logic [4:0] KERNEL_MAX   = 5'd16;

  // divisibility check runs one map bit per cycle
  localparam logic [3:0] MOD_LAST = 4'd8;

  // plane position counters
  localparam int CNT_W = 9;
  localparam int WIN_W = 4;

  // configuration seen by the datapath
  typedef struct packed {
    logic [4:0] kernel_size;
    logic [8:0] map_size;
    logic [8:0] k_sq;
    logic       bad;
    logic       busy;
  } cfg_state_t;

  // per-pixel control carried along the pipeline
  typedef struct packed {
    logic       first;
    logic       emit;
    logic       plane_last;
    logic       err;
    logic [7:0] out_row;
    logic [7:0] out_col;
  } pool_tag_t;

endpackage

### hdl/avgp_if.sv
// stream interfaces for pixels in and pooled results out
interface avgp_in_if #(parameter int PIXEL_WIDTH = 16) ();
  logic                          valid;
  logic                          ready;
  logic signed [PIXEL_WIDTH-1:0] pixel;

  modport source(output valid, output pixel, input ready);
  modport sink(input valid, input pixel, output ready);
endinterface

interface avgp_out_if #(parameter int PIXEL_WIDTH = 16) ();
  logic                          valid;
  logic                          ready;
  logic signed [PIXEL_WIDTH-1:0] average;
  logic [7:0]                    out_row;
  logic [7:0]                    out_col;
  logic                          plane_last;
  logic                          config_error;

  modport source(output valid, output average, output out_row, output out_col,
                 output plane_last, output config_error, input ready);
  modport sink(input valid, input average, input out_row, input out_col,
               input plane_last, input config_error, output ready);
endinterface

### hdl/average_pool_stream.sv
// Non-overlapping KxK average pooling over a stream of square planes. Pixels
// come in raster order, one plane after another; each is divided by K*K
// (truncating toward zero) in a pipelined restoring divider of PIXEL_WIDTH
// stages and then added into a per-pooled-column partial sum held in a
// MAX_SIZE-entry memory, read one cycle and written back the next with the
// latest write forwarded. One pixel is taken per cycle unless the pipeline
// stalls; a result passes the divider stages and the second accumulator
// stage, and a single output register holds each result until it transfers.
// A stall on the result side stalls the whole pipeline. After any
// configuration write the input holds off while the map size is checked
// against the kernel size one bit per cycle; if the configuration is
// unusable each pixel yields a result with config_error set and the other
// fields zero. A configuration write also restarts the plane position.
`include "average_pool_stream_defines.svh"

module average_pool_stream #(
  parameter int MAX_SIZE    = 256,
  parameter int PIXEL_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  avgp_in_if.sink                         pixels,
  avgp_out_if.source                      results,
  input  logic                            cfg_we,
  input  logic [avgp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [avgp_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int ADDR_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

  avgp_pkg::cfg_state_t cfg;
  logic                 adv;
  logic                 accept;

  // plane position
  logic [avgp_pkg::CNT_W-1:0] in_row, in_col, pooled_row, pooled_col;
  logic [avgp_pkg::WIN_W-1:0] window_row, window_col;
  logic                       wc_last, wr_last, col_last, row_last;

  avgp_pkg::pool_tag_t  in_tag;
  logic [ADDR_W-1:0]    in_addr;

  logic                   a1_valid, a1_neg;
  logic [PIXEL_WIDTH-1:0] a1_quot;
  avgp_pkg::pool_tag_t    a1_tag;
  logic [ADDR_W-1:0]      a1_addr;

  logic                   res_valid;
  logic [PIXEL_WIDTH-1:0] res_average;
  avgp_pkg::pool_tag_t    res_tag;

  logic                   out_valid;
  logic [PIXEL_WIDTH-1:0] out_average;
  avgp_pkg::pool_tag_t    out_tag;

  avgp_cfg #(.MAX_SIZE(MAX_SIZE)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .state     (cfg)
  );

  // pipeline moves whenever the output register can take a result
  assign adv          = !out_valid || results.ready;
  assign pixels.ready = adv && !cfg.busy;
  assign accept       = pixels.valid && pixels.ready;

  // window and plane edges
  assign wc_last  = {1'b0, window_col} == (cfg.kernel_size - 5'd1);
  assign wr_last  = {1'b0, window_row} == (cfg.kernel_size - 5'd1);
  assign col_last = in_col == (cfg.map_size - 9'd1);
  assign row_last = in_row == (cfg.map_size - 9'd1);

  // tag for the incoming pixel
  always_comb begin
    in_tag = '0;
    if (cfg.bad) begin
      in_tag.err  = 1'b1;
      in_tag.emit = 1'b1;
    end else begin
      in_tag.first      = (window_row == '0) && (window_col == '0);
      in_tag.emit       = wr_last && wc_last;
      in_tag.plane_last = row_last && col_last;
      in_tag.out_row    = pooled_row[7:0];
      in_tag.out_col    = pooled_col[7:0];
    end
  end
  assign in_addr = ADDR_W'(pooled_col);

  // position counters
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      in_row     <= '0;
      in_col     <= '0;
      pooled_row <= '0;
      pooled_col <= '0;
      window_row <= '0;
      window_col <= '0;
    end else if (accept && !cfg.bad) begin
      if (col_last) begin
        in_col     <= '0;
        window_col <= '0;
        pooled_col <= '0;
        if (row_last) begin
          in_row     <= '0;
          window_row <= '0;
          pooled_row <= '0;
        end else begin
          in_row <= in_row + 9'd1;
          if (wr_last) begin
            window_row <= '0;
            pooled_row <= pooled_row + 9'd1;
          end else begin
            window_row <= window_row + 4'd1;
          end
        end
      end else begin
        in_col <= in_col + 9'd1;
        if (wc_last) begin
          window_col <= '0;
          pooled_col <= pooled_col + 9'd1;
        end else begin
          window_col <= window_col + 4'd1;
        end
      end
    end
  end

  avgp_div #(.PIXEL_WIDTH(PIXEL_WIDTH), .ADDR_W(ADDR_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (accept),
    .pixel     (pixels.pixel),
    .in_tag    (in_tag),
    .in_addr   (in_addr),
    .k_sq      (cfg.k_sq),
    .out_valid (a1_valid),
    .quot      (a1_quot),
    .neg_out   (a1_neg),
    .out_tag   (a1_tag),
    .out_addr  (a1_addr)
  );

  avgp_acc #(.PIXEL_WIDTH(PIXEL_WIDTH), .MAX_SIZE(MAX_SIZE), .ADDR_W(ADDR_W)) u_acc (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .a1_valid    (a1_valid),
    .a1_quot     (a1_quot),
    .a1_neg      (a1_neg),
    .a1_tag      (a1_tag),
    .a1_addr     (a1_addr),
    .res_valid   (res_valid),
    .res_average (res_average),
    .res_tag     (res_tag)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_average <= res_average;
      out_tag     <= res_tag;
    end
  end

  assign results.valid        = out_valid;
  assign results.average      = out_average;
  assign results.out_row      = out_tag.out_row;
  assign results.out_col      = out_tag.out_col;
  assign results.plane_last   = out_tag.plane_last;
  assign results.config_error = out_tag.err;

  // checks
  `AVGP_ASSERT_NEXT(a_cfg_restart, clk, rst, cfg_we, (in_col == '0) && (in_row == '0) && (pooled_col == '0))
  `AVGP_ASSERT_IMPL(a_window_bound, clk, rst, !cfg.busy && !cfg.bad, ({1'b0, window_col} < cfg.kernel_size) && ({1'b0, window_row} < cfg.kernel_size))
  `AVGP_ASSERT_IMPL(a_last_on_diag, clk, rst, results.valid && results.plane_last, results.out_row == results.out_col)

endmodule

### hdl/avgp_cfg.sv
// configuration registers and map/kernel divisibility check
module avgp_cfg #(
  parameter int MAX_SIZE = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [avgp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [avgp_pkg::CFG_DATA_W-1:0]     cfg_data,
  output avgp_pkg::cfg_state_t                state
);

  logic [4:0] kernel_size, kernel_size_next;
  logic [8:0] map_size, map_size_next;
  logic       busy;
  logic [3:0] step;
  logic [4:0] rem;
  logic [4:0] rem_next;
  logic [8:0] shift;
  logic       bad;
  logic [8:0] k_sq;
  logic [5:0] trial;
  logic       ge;
  logic       range_bad;
  logic [9:0] k_prod;

  // register write decode
  always_comb begin
    kernel_size_next = kernel_size;
    map_size_next    = map_size;
    if (cfg_we) begin
      case (cfg_index)
        avgp_pkg::REG_KERNEL_SIZE: kernel_size_next = cfg_data[4:0];
        avgp_pkg::REG_MAP_SIZE:    map_size_next    = cfg_data;
        default: ;
      endcase
    end
  end

  // restoring remainder step, one map bit per cycle
  assign trial    = {rem, shift[8]};
  assign ge       = trial >= {1'b0, kernel_size};
  assign rem_next = ge ? 5'(trial - {1'b0, kernel_size}) : trial[4:0];

  assign range_bad = (kernel_size == 5'd0) || (kernel_size > avgp_pkg::KERNEL_MAX) ||
                     (map_size == 9'd0) || ({23'b0, map_size} > 32'(MAX_SIZE));
  assign k_prod    = 10'(kernel_size) * 10'(kernel_size);

  // registers and check sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_size <= avgp_pkg::KERNEL_RESET;
      map_size    <= avgp_pkg::MAP_RESET;
      busy        <= 1'b0;
      step        <= 4'd0;
      rem         <= 5'd0;
      shift       <= 9'd0;
      bad         <= 1'b0;
      k_sq        <= avgp_pkg::KSQ_RESET;
    end else begin
      kernel_size <= kernel_size_next;
      map_size    <= map_size_next;
      if (cfg_we) begin
        busy  <= 1'b1;
        step  <= 4'd0;
        rem   <= 5'd0;
        shift <= map_size_next;
      end else if (busy) begin
        rem   <= rem_next;
        shift <= {shift[7:0], 1'b0};
        step  <= step + 4'd1;
        if (step == avgp_pkg::MOD_LAST) begin
          busy <= 1'b0;
          bad  <= range_bad || (rem_next != 5'd0);
          k_sq <= k_prod[8:0];
        end
      end
    end
  end

  assign state.kernel_size = kernel_size;
  assign state.map_size    = map_size;
  assign state.k_sq        = k_sq;
  assign state.bad         = bad;
  assign state.busy        = busy;

endmodule

### hdl/avgp_div.sv
// pipelined restoring divider: pixel magnitude by K*K, one quotient bit per stage
module avgp_div #(
  parameter int PIXEL_WIDTH = 16,
  parameter int ADDR_W      = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic signed [PIXEL_WIDTH-1:0] pixel,
  input  avgp_pkg::pool_tag_t           in_tag,
  input  logic [ADDR_W-1:0]             in_addr,
  input  logic [8:0]                    k_sq,
  output logic                          out_valid,
  output logic [PIXEL_WIDTH-1:0]        quot,
  output logic                          neg_out,
  output avgp_pkg::pool_tag_t           out_tag,
  output logic [ADDR_W-1:0]             out_addr
);

  localparam int W = PIXEL_WIDTH;

  logic [W:0]                vld;
  logic [W-1:0]              mag   [0:W];
  logic [7:0]                rem   [0:W];
  logic                      neg   [0:W];
  avgp_pkg::pool_tag_t       tag   [0:W];
  logic [ADDR_W-1:0]         addr  [0:W];
  logic [8:0]                trial [0:W-1];
  logic                      ge    [0:W-1];
  logic [7:0]                rem_step [0:W-1];
  logic [W-1:0]              mag_step [0:W-1];
  logic [W-1:0]              pix_mag;

  // magnitude of the pixel, the most negative value maps to 2^(W-1)
  assign pix_mag = pixel[W-1] ? $unsigned(-pixel) : $unsigned(pixel);

  // one trial subtraction per stage, quotient bits shift in at the bottom
  always_comb begin
    for (int j = 0; j < W; j++) begin
      trial[j]    = {rem[j], mag[j][W-1]};
      ge[j]       = trial[j] >= k_sq;
      rem_step[j] = ge[j] ? 8'(trial[j] - k_sq) : trial[j][7:0];
      mag_step[j] = {mag[j][W-2:0], ge[j]};
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[W-1:0], in_valid};
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      mag[0]  <= pix_mag;
      rem[0]  <= 8'd0;
      neg[0]  <= pixel[W-1];
      tag[0]  <= in_tag;
      addr[0] <= in_addr;
      for (int j = 1; j <= W; j++) begin
        mag[j]  <= mag_step[j-1];
        rem[j]  <= rem_step[j-1];
        neg[j]  <= neg[j-1];
        tag[j]  <= tag[j-1];
        addr[j] <= addr[j-1];
      end
    end
  end

  assign out_valid = vld[W];
  assign quot      = mag[W];
  assign neg_out   = neg[W];
  assign out_tag   = tag[W];
  assign out_addr  = addr[W];

endmodule

### hdl/avgp_acc.sv
// column partial-sum memory with read-modify-write and write forwarding
module avgp_acc #(
  parameter int PIXEL_WIDTH = 16,
  parameter int MAX_SIZE    = 256,
  parameter int ADDR_W      = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   a1_valid,
  input  logic [PIXEL_WIDTH-1:0] a1_quot,
  input  logic                   a1_neg,
  input  avgp_pkg::pool_tag_t    a1_tag,
  input  logic [ADDR_W-1:0]      a1_addr,
  output logic                   res_valid,
  output logic [PIXEL_WIDTH-1:0] res_average,
  output avgp_pkg::pool_tag_t    res_tag
);

  logic [PIXEL_WIDTH-1:0] mem [MAX_SIZE];
  logic [PIXEL_WIDTH-1:0] rdata;
  logic                   a2_valid;
  logic [PIXEL_WIDTH-1:0] a2_q;
  avgp_pkg::pool_tag_t    a2_tag;
  logic [ADDR_W-1:0]      a2_addr;
  logic                   fwd_valid;
  logic [ADDR_W-1:0]      fwd_addr;
  logic [PIXEL_WIDTH-1:0] fwd_data;
  logic [PIXEL_WIDTH-1:0] base;
  logic [PIXEL_WIDTH-1:0] sum;
  logic                   we;

  // memory read, data arrives with the item in the second stage
  always_ff @(posedge clk) begin
    if (adv) begin
      rdata <= mem[a1_addr];
    end
  end

  // memory write
  always_ff @(posedge clk) begin
    if (adv && we) begin
      mem[a2_addr] <= sum;
    end
  end

  // second stage: signed quotient and tag
  always_ff @(posedge clk) begin
    if (rst) begin
      a2_valid <= 1'b0;
    end else if (adv) begin
      a2_valid <= a1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a2_q    <= a1_neg ? (PIXEL_WIDTH'(0) - a1_quot) : a1_quot;
      a2_tag  <= a1_tag;
      a2_addr <= a1_addr;
    end
  end

  // last write bypasses the read it raced with
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (adv) begin
      fwd_valid <= we;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_addr <= a2_addr;
      fwd_data <= sum;
    end
  end

  // window start loads, the rest accumulate with wraparound
  assign base = (fwd_valid && (fwd_addr == a2_addr)) ? fwd_data : rdata;
  assign sum  = a2_tag.first ? a2_q : PIXEL_WIDTH'(base + a2_q);
  assign we   = a2_valid && !a2_tag.err;

  assign res_valid   = a2_valid && a2_tag.emit;
  assign res_average = a2_tag.err ? '0 : sum;
  assign res_tag     = a2_tag;

endmodule
